// ===== rtl/ecc_pkg.sv =====
// ============================================================================
// ecc_pkg - shared types and constants of the epoch calendar converter
// Request and result payloads, conversion codes, calendar constants and
// the reciprocal factors used for the constant divisions.
// ============================================================================
package ecc_pkg;

    // Conversion codes carried in req_type
    localparam logic [1:0] REQ_DATE_TO_SECS = 2'd0;
    localparam logic [1:0] REQ_SECS_TO_TIME = 2'd1;
    localparam logic [1:0] REQ_DAYS_TO_DATE = 2'd2;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [15:0] DAYS_LIMIT   = 16'd47482;   // first day of 2100

    // Reciprocal factors: floor(2^shift / divisor); the quotient estimate is
    // short by at most one and is fixed with a single compare and subtract.
    localparam logic [31:0] DIV60_MUL_HI   = 32'd2290649224;
    localparam int          DIV60_SHIFT_HI = 37;
    localparam logic [26:0] DIV60_MUL_LO   = 27'd71582788;
    localparam int          DIV60_SHIFT_LO = 32;
    localparam logic [19:0] DIV24_MUL      = 20'd699050;
    localparam int          DIV24_SHIFT    = 24;
    localparam logic [15:0] DIV365_MUL     = 16'd45964;
    localparam int          DIV365_SHIFT   = 24;

    // Days before the first of each month in a common year
    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [31:0] count_in;
    } ecc_req_t;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        out_of_range;
    } ecc_res_t;

    // Day of year at which a 0-based month starts; zero past December
    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] d;
        d = 9'd0;
        if (month < 4'd12)
        begin
            d = CUM_DAYS[month];
            if (month > 4'd1 && leap)
            begin
                d = d + 9'd1;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/ecc_req_if.sv =====
// ============================================================================
// ecc_req_if - request channel of the epoch calendar converter
// Valid/ready channel carrying one conversion request per transfer.
// ============================================================================
interface ecc_req_if;
    logic             valid;
    logic             ready;
    ecc_pkg::ecc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ecc_res_if.sv =====
// ============================================================================
// ecc_res_if - result channel of the epoch calendar converter
// Valid/ready channel carrying one conversion result per transfer.
// ============================================================================
interface ecc_res_if;
    logic             valid;
    logic             ready;
    ecc_pkg::ecc_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/epoch_calendar_converter_top.sv =====
// ============================================================================
// epoch_calendar_converter_top - date, time-of-day and day-count converter
// Six-stage pipeline for the years 1970 to 2099 (every fourth year leap).
// ============================================================================
// Each request transfer yields exactly one result transfer, and a new request
// is taken in every cycle unless every stage is full and the result side stalls.
// The pipeline depth is set by the seconds-to-time path, which divides by 60,
// 60 and 24 in turn, each division a reciprocal multiply stage followed by a
// correction stage. Each stage holds its item while the stage after it is
// full and stalled, so empty stages keep accepting requests while a finished
// result waits to be taken. Fields that a conversion does not produce are zero.
module epoch_calendar_converter_top (
    input  logic      clk,
    input  logic      rst_n,
    ecc_req_if.sink   req,
    ecc_res_if.source res
);

    localparam int STAGES = 6;

    typedef struct packed {
        logic [1:0]  typ;
        logic [31:0] count;
        logic [63:0] prod;
        logic [11:0] span;
        logic        leap;
        logic [8:0]  ms;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [19:0] days;
        logic [16:0] hm;
        logic [26:0] mins;
        logic [20:0] hours;
        logic [5:0]  second;
        logic        oor;
        logic [19:0] ys;
        logic [8:0]  rem;
        logic [3:0]  month;
        logic [11:0] year;
        logic [31:0] seconds;
    } stage_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] adv;

    stage_t s1_reg, s1_next;
    stage_t s2_reg, s2_next;
    stage_t s3_reg, s3_next;
    stage_t s4_reg, s4_next;
    stage_t s5_reg, s5_next;
    ecc_pkg::ecc_res_t res_reg, res_next;
    logic [1:0] typ6_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || res.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign req.ready = adv[0];
    assign res.valid = valid_reg[STAGES-1];
    assign res.data  = res_reg;

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= req.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamp year, look up month start, flag day counts out of range, start the first division
    always_comb
    begin
        logic [11:0] yc;
        s1_next        = '0;
        s1_next.typ    = req.data.req_type;
        s1_next.count  = req.data.count_in;
        s1_next.day    = req.data.day_in;
        s1_next.hour   = req.data.hour_in;
        s1_next.minute = req.data.minute_in;
        yc = (req.data.year_in < ecc_pkg::EPOCH_YEAR) ? ecc_pkg::EPOCH_YEAR
                                                      : req.data.year_in;
        case (req.data.req_type)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                s1_next.span = yc - ecc_pkg::EPOCH_YEAR;
                s1_next.leap = (yc[1:0] == 2'b00);
                s1_next.ms   = ecc_pkg::month_start(req.data.month_in, yc[1:0] == 2'b00);
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                s1_next.prod = 64'(req.data.count_in) * 64'(ecc_pkg::DIV60_MUL_HI);
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                s1_next.oor  = (req.data.count_in >= 32'(ecc_pkg::DAYS_LIMIT));
                s1_next.prod = 64'(req.data.count_in[15:0]) * 64'(ecc_pkg::DIV365_MUL);
            end
            default:
            begin
                s1_next.typ = req.data.req_type;
            end
        endcase
    end

    // Stage 2: day count and hour/minute seconds; fix the first quotients
    always_comb
    begin
        logic [26:0] q27;
        logic [31:0] r32;
        logic [7:0]  q8;
        logic [15:0] r16;
        s2_next = s1_reg;
        q27 = 27'(s1_reg.prod >> ecc_pkg::DIV60_SHIFT_HI);
        r32 = s1_reg.count - ({5'd0, q27} * 32'd60);
        q8  = 8'(s1_reg.prod >> ecc_pkg::DIV365_SHIFT);
        r16 = s1_reg.count[15:0] - 16'(q8) * 16'(ecc_pkg::DAYS_COMMON);
        case (s1_reg.typ)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                s2_next.days = 20'(s1_reg.span) * 20'(ecc_pkg::DAYS_COMMON)
                             + 20'((s1_reg.span + 12'd1) >> 2)
                             + 20'(s1_reg.ms) + 20'(s1_reg.day);
                s2_next.hm   = 17'(s1_reg.hour) * 17'd3600 + 17'(s1_reg.minute) * 17'd60;
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                if (r32 >= 32'd60)
                begin
                    s2_next.mins   = q27 + 27'd1;
                    s2_next.second = 6'(r32 - 32'd60);
                end
                else
                begin
                    s2_next.mins   = q27;
                    s2_next.second = 6'(r32);
                end
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                s2_next.span = 12'(q8) + ((r16 >= 16'(ecc_pkg::DAYS_COMMON)) ? 12'd1 : 12'd0);
            end
            default:
            begin
                s2_next.typ = s1_reg.typ;
            end
        endcase
    end

    // Stage 3: scale days to seconds, start minutes/60, year start of span
    always_comb
    begin
        s3_next = s2_reg;
        case (s2_reg.typ)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                s3_next.prod = 64'(s2_reg.days) * 64'(ecc_pkg::SECS_PER_DAY);
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                s3_next.prod = 64'(s2_reg.mins) * 64'(ecc_pkg::DIV60_MUL_LO);
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                s3_next.ys = 20'(s2_reg.span) * 20'(ecc_pkg::DAYS_COMMON)
                           + 20'((s2_reg.span + 12'd1) >> 2);
            end
            default:
            begin
                s3_next.typ = s2_reg.typ;
            end
        endcase
    end

    // Stage 4: final seconds sum, fix minutes, step span back on overshoot
    always_comb
    begin
        logic [21:0] q22;
        logic [27:0] r28;
        logic [11:0] span_s;
        logic [19:0] ys_s;
        s4_next = s3_reg;
        q22 = 22'(s3_reg.prod >> ecc_pkg::DIV60_SHIFT_LO);
        r28 = {1'b0, s3_reg.mins} - 28'(q22) * 28'd60;
        span_s = s3_reg.span;
        ys_s   = s3_reg.ys;
        if (s3_reg.ys > {4'd0, s3_reg.count[15:0]})
        begin
            span_s = s3_reg.span - 12'd1;
            ys_s   = s3_reg.ys - 20'(ecc_pkg::DAYS_COMMON)
                   - ((s3_reg.span[1:0] == 2'b11) ? 20'd1 : 20'd0);
        end
        case (s3_reg.typ)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                s4_next.seconds = s3_reg.prod[31:0] + 32'(s3_reg.hm);
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                if (r28 >= 28'd60)
                begin
                    s4_next.hours  = 21'(q22 + 22'd1);
                    s4_next.minute = 6'(r28 - 28'd60);
                end
                else
                begin
                    s4_next.hours  = 21'(q22);
                    s4_next.minute = 6'(r28);
                end
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                s4_next.span = span_s;
                s4_next.rem  = 9'(s3_reg.count[15:0] - ys_s[15:0]);
                s4_next.year = ecc_pkg::EPOCH_YEAR + span_s;
                s4_next.leap = (span_s[1:0] == 2'b10);
            end
            default:
            begin
                s4_next.typ = s3_reg.typ;
            end
        endcase
    end

    // Stage 5: start hours/24, pick the month holding the day of year
    always_comb
    begin
        s5_next = s4_reg;
        case (s4_reg.typ)
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                s5_next.prod = 64'(s4_reg.hours) * 64'(ecc_pkg::DIV24_MUL);
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                s5_next.month = 4'd0;
                for (int m = 1; m < 12; m++)
                begin
                    if (ecc_pkg::month_start(4'(m), s4_reg.leap) <= s4_reg.rem)
                    begin
                        s5_next.month = 4'(m);
                    end
                end
            end
            default:
            begin
                s5_next.typ = s4_reg.typ;
            end
        endcase
    end

    // Stage 6: assemble the result, zero what the conversion leaves out
    always_comb
    begin
        logic [16:0] q17;
        logic [21:0] r22;
        res_next = '0;
        q17 = 17'(s5_reg.prod >> ecc_pkg::DIV24_SHIFT);
        r22 = {1'b0, s5_reg.hours} - 22'(q17) * 22'd24;
        case (s5_reg.typ)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                res_next.seconds_out = s5_reg.seconds;
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                res_next.hour_out   = 5'((r22 >= 22'd24) ? (r22 - 22'd24) : r22);
                res_next.minute_out = s5_reg.minute;
                res_next.second_out = s5_reg.second;
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                if (s5_reg.oor)
                begin
                    res_next.out_of_range = 1'b1;
                end
                else
                begin
                    res_next.year_out  = s5_reg.year;
                    res_next.month_out = s5_reg.month;
                    res_next.day_out   = 5'(s5_reg.rem
                                       - ecc_pkg::month_start(s5_reg.month, s5_reg.leap));
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // Load stage payloads on advance
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= s1_next;
        end
        if (adv[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
        if (adv[3])
        begin
            s4_reg <= s4_next;
        end
        if (adv[4])
        begin
            s5_reg <= s5_next;
        end
        if (adv[5])
        begin
            res_reg  <= res_next;
            typ6_reg <= s5_reg.typ;
        end
    end

`ifndef NO_ASSERTIONS
    // Items in flight change only by request and result transfers
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg))
                 + $past(int'(req.valid && req.ready))
                 - $past(int'(res.valid && res.ready)))
        else $error("pipeline occupancy does not match transfers");

    // Requests are refused only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (&valid_reg) && !res.ready)
        else $error("request refused while the pipeline has room");

    // Out of range is flagged only for day counts and carries no date
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.out_of_range |->
            typ6_reg == ecc_pkg::REQ_DAYS_TO_DATE && res.data.year_out == 12'd0
            && res.data.month_out == 4'd0 && res.data.day_out == 5'd0)
        else $error("out_of_range result with date fields set");

    // Second counts appear only on date-to-seconds results
    a_secs_only_t0: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && typ6_reg != ecc_pkg::REQ_DATE_TO_SECS |->
            res.data.seconds_out == 32'd0)
        else $error("seconds_out set on a result of another conversion");
`endif

endmodule

// ===== tb/epoch_calendar_converter_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// epoch_calendar_converter_top_test - self-checking bench for the converter
// Feeds date, time-of-day and day-count conversions through the valid/ready
// request channel with bursty traffic, stalls the result channel on its own
// pattern (with one long hold-off), and compares every result field against
// a calendar model kept in the bench.
// ============================================================================
module epoch_calendar_converter_top_test;

    // Request code with no conversion behind it
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int unsigned BASE_YEAR      = 1970;
    localparam int unsigned LAST_DAY_LIMIT = 47482;   // day count of 2100-01-01
    localparam int unsigned RANDOM_ITEMS   = 930;
    localparam int          IDLE_LIMIT     = 2000;
    localparam int          HOLD_OFF_CYCLES = 120;
    localparam int          HOLD_OFF_AFTER  = 250;

    localparam int unsigned MONTH_OFFSET [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic clk;
    logic rst_n;

    ecc_req_if req_ch ();
    ecc_res_if res_ch ();

    epoch_calendar_converter_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    ecc_pkg::ecc_req_t conversion_queue [$];
    ecc_pkg::ecc_res_t predicted_conversions [$];

    int total_items;
    int tx_count;
    int rx_count;
    int mismatches;
    int idle_cycles;
    bit req_taken;

    // Sender burst state
    int burst_left;
    int gap_left;

    // Receiver stall state
    int stall_mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    int rx_cycle;
    logic ready_next;

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------

    // Days from 1970-01-01 to January 1st of year 1970+span
    function automatic logic [31:0] days_to_year(input logic [31:0] span);
        return span * 32'd365 + (span + 32'd1) / 32'd4;
    endfunction

    // Days from January 1st to the first of a 0-based month; zero past December
    function automatic logic [31:0] month_lead_days(input logic [31:0] year,
                                                    input logic [3:0] month);
        logic [31:0] d;
        d = 32'd0;
        if (month < 4'd12)
        begin
            d = MONTH_OFFSET[month];
            if (month > 4'd1 && year[1:0] == 2'b00)
            begin
                d = d + 32'd1;
            end
        end
        return d;
    endfunction

    function automatic ecc_pkg::ecc_res_t convert_calendar(input ecc_pkg::ecc_req_t r);
        ecc_pkg::ecc_res_t outcome;
        logic [31:0] year;
        logic [31:0] days;
        logic [31:0] span;
        logic [31:0] rem;
        logic [3:0]  m;
        outcome = '0;
        case (r.req_type)
            ecc_pkg::REQ_DATE_TO_SECS:
            begin
                // Clamp early years to the epoch, then sum and let it wrap
                year = {20'd0, r.year_in};
                if (year < BASE_YEAR)
                begin
                    year = BASE_YEAR;
                end
                days = days_to_year(year - BASE_YEAR) + month_lead_days(year, r.month_in)
                       + {27'd0, r.day_in};
                outcome.seconds_out = days * 32'd86400 + {27'd0, r.hour_in} * 32'd3600
                                      + {26'd0, r.minute_in} * 32'd60;
            end
            ecc_pkg::REQ_SECS_TO_TIME:
            begin
                outcome.hour_out   = 5'((r.count_in / 32'd3600) % 32'd24);
                outcome.minute_out = 6'((r.count_in / 32'd60) % 32'd60);
                outcome.second_out = 6'(r.count_in % 32'd60);
            end
            ecc_pkg::REQ_DAYS_TO_DATE:
            begin
                if (r.count_in >= LAST_DAY_LIMIT)
                begin
                    outcome.out_of_range = 1'b1;
                end
                else
                begin
                    // Estimate the year, step back once if it overshoots
                    span = r.count_in / 32'd365;
                    if (days_to_year(span) > r.count_in)
                    begin
                        span = span - 32'd1;
                    end
                    rem  = r.count_in - days_to_year(span);
                    year = BASE_YEAR + span;
                    m    = 4'd11;
                    while (m > 4'd0 && rem < month_lead_days(year, m))
                    begin
                        m = m - 4'd1;
                    end
                    rem = rem - month_lead_days(year, m);
                    outcome.year_out  = year[11:0];
                    outcome.month_out = m;
                    outcome.day_out   = rem[4:0];
                end
            end
            default:
            begin
                outcome = '0;
            end
        endcase
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Request with every field random; callers overwrite what matters
    function automatic ecc_pkg::ecc_req_t noise_req();
        ecc_pkg::ecc_req_t r;
        r.req_type  = 2'($urandom);
        r.year_in   = 12'($urandom);
        r.month_in  = 4'($urandom);
        r.day_in    = 5'($urandom);
        r.hour_in   = 5'($urandom);
        r.minute_in = 6'($urandom);
        r.count_in  = $urandom;
        return r;
    endfunction

    task automatic push_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi);
        ecc_pkg::ecc_req_t r;
        r = noise_req();
        r.req_type  = ecc_pkg::REQ_DATE_TO_SECS;
        r.year_in   = 12'(y);
        r.month_in  = 4'(mo);
        r.day_in    = 5'(d);
        r.hour_in   = 5'(h);
        r.minute_in = 6'(mi);
        conversion_queue.push_back(r);
    endtask

    task automatic push_count(input logic [1:0] kind, input logic [31:0] value);
        ecc_pkg::ecc_req_t r;
        r = noise_req();
        r.req_type = kind;
        r.count_in = value;
        conversion_queue.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch in %s of result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                         field, rx_count, want, want, got, got);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver: bursts of transfers with random gaps, changes on falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            // Drop the item taken at the last rising edge
            if (req_taken)
            begin
                void'(conversion_queue.pop_front());
            end

            if (req_ch.valid && !req_taken)
            begin
                // Hold the offered item until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (conversion_queue.size() > 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= conversion_queue[0];
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall modes picked at random in turn,
    // plus one long hold-off once traffic is flowing
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(3);
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;

            if (!hold_done && rx_count >= HOLD_OFF_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end

            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = ($urandom_range(3) != 0);
                2:       ready_next = ($urandom_range(3) == 0);
                default: ready_next = (rx_cycle % 7 != 3) && (rx_cycle % 5 != 0);
            endcase

            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            res_ch.ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each request transfer, check each result transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken   = 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
            begin
                predicted_conversions.push_back(convert_calendar(req_ch.data));
                tx_count++;
            end

            if (res_ch.valid && res_ch.ready)
            begin
                if (predicted_conversions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d arrived with nothing outstanding", rx_count);
                    end
                end
                else
                begin
                    ecc_pkg::ecc_res_t want;
                    want = predicted_conversions.pop_front();
                    check_field("seconds_out", want.seconds_out, res_ch.data.seconds_out);
                    check_field("year_out", 32'(want.year_out), 32'(res_ch.data.year_out));
                    check_field("month_out", 32'(want.month_out), 32'(res_ch.data.month_out));
                    check_field("day_out", 32'(want.day_out), 32'(res_ch.data.day_out));
                    check_field("hour_out", 32'(want.hour_out), 32'(res_ch.data.hour_out));
                    check_field("minute_out", 32'(want.minute_out),
                                32'(res_ch.data.minute_out));
                    check_field("second_out", 32'(want.second_out),
                                32'(res_ch.data.second_out));
                    check_field("out_of_range", 32'(want.out_of_range),
                                32'(res_ch.data.out_of_range));
                end
                rx_count++;
            end

            // Watchdog: end the run when nothing moves for too long
            if (req_taken || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                    $display("** epoch_calendar_converter_top: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        ecc_pkg::ecc_req_t r;
        int       pick;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        req_taken    = 1'b0;
        tx_count     = 0;
        rx_count     = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        burst_left   = $urandom_range(1, 40);
        gap_left     = 0;
        stall_mode   = 0;
        mode_left    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        rx_cycle     = 0;

        // Directed: date to seconds at the edges of the fields
        push_date(1970, 0, 0, 0, 0);
        push_date(2099, 11, 30, 23, 59);
        push_date(0, 5, 10, 12, 30);             // year before the epoch
        push_date(4095, 15, 31, 31, 63);         // far future, bad month, wrap
        push_date(1972, 1, 28, 6, 7);            // leap day
        push_date(1972, 2, 0, 0, 0);             // first of March, leap year
        push_date(1971, 2, 0, 0, 0);             // first of March, common year
        push_date(2000, 12, 3, 1, 1);            // month past December
        // Directed: seconds to time of day
        push_count(ecc_pkg::REQ_SECS_TO_TIME, 32'd0);
        push_count(ecc_pkg::REQ_SECS_TO_TIME, 32'hFFFF_FFFF);
        push_count(ecc_pkg::REQ_SECS_TO_TIME, 32'd86399);
        push_count(ecc_pkg::REQ_SECS_TO_TIME, 32'd86400);
        // Directed: days to date, range ends and leap boundaries
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd0);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd47481);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd47482);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'hFFFF_FFFF);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd789);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd790);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd730);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd729);
        push_count(ecc_pkg::REQ_DAYS_TO_DATE, 32'd59);
        // Directed: unknown request code
        push_count(REQ_UNUSED, $urandom);
        conversion_queue.push_back('1);

        // Random: mostly well-formed conversions, some raw noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                push_date($urandom_range(1970, 2099), $urandom_range(11), $urandom_range(30),
                          $urandom_range(23), $urandom_range(59));
            end
            else if (pick < 38)
            begin
                r = noise_req();
                r.req_type = ecc_pkg::REQ_DATE_TO_SECS;
                conversion_queue.push_back(r);
            end
            else if (pick < 48)
            begin
                push_count(ecc_pkg::REQ_SECS_TO_TIME, $urandom);
            end
            else if (pick < 58)
            begin
                push_count(ecc_pkg::REQ_SECS_TO_TIME, $urandom_range(0, 86400 * 3));
            end
            else if (pick < 88)
            begin
                push_count(ecc_pkg::REQ_DAYS_TO_DATE, $urandom_range(0, LAST_DAY_LIMIT - 1));
            end
            else if (pick < 91)
            begin
                push_count(ecc_pkg::REQ_DAYS_TO_DATE, $urandom_range(LAST_DAY_LIMIT, 50000));
            end
            else if (pick < 95)
            begin
                push_count(ecc_pkg::REQ_DAYS_TO_DATE, $urandom);
            end
            else
            begin
                push_count(REQ_UNUSED, $urandom);
            end
        end
        total_items = conversion_queue.size();

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request is taken and every result is back
        while (tx_count < total_items || predicted_conversions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        if (mismatches == 0 && predicted_conversions.size() == 0)
        begin
            $display("** epoch_calendar_converter_top: PASSED **");
        end
        else
        begin
            $display("** epoch_calendar_converter_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ecc_pkg.sv
rtl/ecc_req_if.sv
rtl/ecc_res_if.sv
rtl/epoch_calendar_converter_top.sv
tb/epoch_calendar_converter_top_test.sv
